@@ rtl/core/cartridge_bus_with_flash_backup_defines.svh @@
// assertion macros for the cartridge bus block
// expects clk and arst_n in the scope of use
`ifndef CARTRIDGE_BUS_WITH_FLASH_BACKUP_DEFINES_SVH
`define CARTRIDGE_BUS_WITH_FLASH_BACKUP_DEFINES_SVH

// same-cycle implication
`define CBFB_ASSERT_IMP(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("cartridge bus check failed");

// next-cycle implication
`define CBFB_ASSERT_NXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("cartridge bus check failed");

`endif

@@ rtl/core/cbfb_pkg.sv @@
// shared types, constants and helpers of the cartridge bus block
// no dependencies
package cbfb_pkg;

	localparam int ROM_ADDR_BITS    = 20;
	localparam int BACKUP_ADDR_BITS = 17;
	localparam int LANES            = 4;
	localparam int LANE_W           = 2;
	localparam int ROM_ROW_W        = ROM_ADDR_BITS - LANE_W;
	localparam int BK_ROW_W         = BACKUP_ADDR_BITS - LANE_W;
	localparam int ROM_ROWS         = 1 << ROM_ROW_W;
	localparam int BK_ROWS          = 1 << BK_ROW_W;
	localparam int ROM_OFS_W        = 25;
	localparam int CFG_W            = 26;
	localparam int KIND_W           = 3;
	localparam int Q_DEPTH          = 2;
	localparam int Q_PTR_W          = $clog2(Q_DEPTH);
	localparam int Q_CNT_W          = $clog2(Q_DEPTH + 1);

	localparam logic [0:0] CFG_BACKUP_KIND = 1'd0;
	localparam logic [0:0] CFG_ROM_BYTES   = 1'd1;

	typedef enum logic [1:0] {
		ACT_READ  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_LOAD  = 2'd2,
		ACT_NOP   = 2'd3
	} action_t;

	localparam logic [1:0] SZ_BYTE = 2'd0;
	localparam logic [1:0] SZ_HALF = 2'd1;
	localparam logic [1:0] SZ_WORD = 2'd2;

	localparam logic [KIND_W-1:0] BK_EEPROM   = 3'd1;
	localparam logic [KIND_W-1:0] BK_SRAM     = 3'd2;
	localparam logic [KIND_W-1:0] BK_FLASH64  = 3'd3;
	localparam logic [KIND_W-1:0] BK_FLASH128 = 3'd4;

	localparam logic [3:0] REGION_ROM_LO = 4'h8;
	localparam logic [3:0] REGION_ROM_HI = 4'hD;
	localparam logic [3:0] REGION_BACKUP = 4'hE;

	localparam logic [BACKUP_ADDR_BITS-1:0] MASK_EEPROM   = 17'h01FFF;
	localparam logic [BACKUP_ADDR_BITS-1:0] MASK_SRAM     = 17'h07FFF;
	localparam logic [BACKUP_ADDR_BITS-1:0] MASK_FLASH64  = 17'h0FFFF;
	localparam logic [BACKUP_ADDR_BITS-1:0] MASK_FLASH128 = 17'h1FFFF;

	localparam logic [BACKUP_ADDR_BITS-1:0] FL_CMD1_ADDR = 17'h05555;
	localparam logic [BACKUP_ADDR_BITS-1:0] FL_CMD2_ADDR = 17'h02AAA;
	localparam logic [BACKUP_ADDR_BITS-1:0] ID_MAKER_OFS = 17'h00000;
	localparam logic [BACKUP_ADDR_BITS-1:0] ID_DEV_OFS   = 17'h00001;
	localparam logic [31:0] FL_KEY1     = 32'h000000AA;
	localparam logic [31:0] FL_KEY2     = 32'h00000055;
	localparam logic [31:0] FL_ID_ENTER = 32'h00000090;
	localparam logic [31:0] FL_ID_EXIT  = 32'h000000F0;
	localparam logic [7:0]  ID_MAKER    = 8'hC2;
	localparam logic [7:0]  ID_DEV64    = 8'h1C;
	localparam logic [7:0]  ID_DEV128   = 8'h09;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_UNMAPPED,
		OP_OPEN_BUS,
		OP_ROM_READ,
		OP_ROM_LOAD,
		OP_BK_READ,
		OP_BK_WRITE,
		OP_FL_WRITE
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR  = 3'b001,
		ST_IDLE   = 3'b010,
		ST_ACCESS = 3'b100
	} back_state_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_KEY1 = 3'b010,
		PH_KEY2 = 3'b100
	} fl_phase_t;

	typedef struct packed {
		logic at_cmd1;
		logic at_cmd2;
		logic key1;
		logic key2;
		logic id_enter;
		logic id_exit;
	} fl_flags_t;

	typedef struct packed {
		op_t                          op;
		logic [1:0]                   size;
		logic [LANE_W-1:0]            lo2;
		logic [LANES-1:0][ROM_ROW_W-1:0] rom_row;
		logic [LANES-1:0][BK_ROW_W-1:0]  bk_row;
		logic [LANES-1:0]             lane_we;
		logic [LANES-1:0][7:0]        lane_data;
		logic [31:0]                  const_data;
		logic                         id_hit;
		logic [7:0]                   id_code;
		fl_flags_t                    fl;
	} cmd_t;

	typedef struct packed {
		logic not_empty;
		logic full;
	} q_status_t;

	typedef struct packed {
		logic clearing;
		logic pop;
	} back_status_t;

	function automatic logic [31:0] gather_bytes(input logic [LANES-1:0][7:0] lanes,
		input logic [LANE_W-1:0] lo2, input logic [1:0] size);
		logic [31:0]       v;
		logic [LANE_W-1:0] idx;
		v = '0;
		for (int i = 0; i < LANES; i++) begin
			idx = lo2 + LANE_W'(i);
			v[8*i +: 8] = lanes[idx];
		end
		if (size == SZ_BYTE) begin
			v[31:8] = '0;
		end else if (size == SZ_HALF) begin
			v[31:16] = '0;
		end
		return v;
	endfunction

endpackage

@@ rtl/core/cbfb_front.sv @@
// front decode: classifies one access and computes lane addresses and data
// depends on cbfb_pkg
module cbfb_front (
	input  logic [1:0]                  action,
	input  logic [31:0]                 address,
	input  logic [1:0]                  access_width,
	input  logic [31:0]                 write_data,
	input  logic [cbfb_pkg::KIND_W-1:0] backup_kind,
	input  logic [cbfb_pkg::CFG_W-1:0]  rom_bytes,
	output cbfb_pkg::cmd_t              cmd
);

	logic [3:0]                               region;
	logic [1:0]                               size;
	logic [1:0]                               we_size;
	logic [31:0]                              data_m;
	logic                                     rom_in_range;
	logic                                     bk_present;
	logic                                     is_flash;
	logic [cbfb_pkg::BACKUP_ADDR_BITS-1:0]    win_mask;
	logic [cbfb_pkg::BACKUP_ADDR_BITS-1:0]    bk_ofs;
	logic [15:0]                              ob_lo;
	logic [15:0]                              ob_hi;
	logic [cbfb_pkg::LANES-1:0][cbfb_pkg::ROM_ROW_W-1:0] rom_row;
	logic [cbfb_pkg::LANES-1:0][cbfb_pkg::BK_ROW_W-1:0]  bk_row;
	logic [cbfb_pkg::LANES-1:0]               lane_en;
	logic [cbfb_pkg::LANES-1:0][7:0]          lane_data;
	cbfb_pkg::op_t                            op;

	assign region       = address[27:24];
	assign rom_in_range = {1'b0, address[cbfb_pkg::ROM_OFS_W-1:0]} < rom_bytes;
	assign bk_present   = (backup_kind == cbfb_pkg::BK_EEPROM) ||
		(backup_kind == cbfb_pkg::BK_SRAM) || (backup_kind == cbfb_pkg::BK_FLASH64) ||
		(backup_kind == cbfb_pkg::BK_FLASH128);
	assign is_flash     = (backup_kind == cbfb_pkg::BK_FLASH64) ||
		(backup_kind == cbfb_pkg::BK_FLASH128);

	always_comb begin
		priority if (access_width == cbfb_pkg::SZ_BYTE) begin
			size   = cbfb_pkg::SZ_BYTE;
			data_m = {24'b0, write_data[7:0]};
		end else if (access_width == cbfb_pkg::SZ_HALF) begin
			size   = cbfb_pkg::SZ_HALF;
			data_m = {16'b0, write_data[15:0]};
		end else begin
			size   = cbfb_pkg::SZ_WORD;
			data_m = write_data;
		end
	end

	// a preload always writes a single byte
	assign we_size = (cbfb_pkg::action_t'(action) == cbfb_pkg::ACT_LOAD) ?
		cbfb_pkg::SZ_BYTE : size;

	always_comb begin
		unique case (backup_kind)
			cbfb_pkg::BK_EEPROM:  win_mask = cbfb_pkg::MASK_EEPROM;
			cbfb_pkg::BK_SRAM:    win_mask = cbfb_pkg::MASK_SRAM;
			cbfb_pkg::BK_FLASH64: win_mask = cbfb_pkg::MASK_FLASH64;
			default:              win_mask = cbfb_pkg::MASK_FLASH128;
		endcase
	end

	assign bk_ofs = address[cbfb_pkg::BACKUP_ADDR_BITS-1:0] & win_mask;

	for (genvar l = 0; l < cbfb_pkg::LANES; l++) begin : g_lane
		logic [cbfb_pkg::LANE_W-1:0]           step;
		logic [cbfb_pkg::ROM_ADDR_BITS-1:0]    rom_sum;
		logic [cbfb_pkg::BACKUP_ADDR_BITS-1:0] bk_sum;

		assign step    = cbfb_pkg::LANE_W'(l) - address[cbfb_pkg::LANE_W-1:0];
		assign rom_sum = address[cbfb_pkg::ROM_ADDR_BITS-1:0] +
			cbfb_pkg::ROM_ADDR_BITS'(step);
		assign bk_sum  = (bk_ofs + cbfb_pkg::BACKUP_ADDR_BITS'(step)) & win_mask;
		assign rom_row[l]   = rom_sum[cbfb_pkg::ROM_ADDR_BITS-1:cbfb_pkg::LANE_W];
		assign bk_row[l]    = bk_sum[cbfb_pkg::BACKUP_ADDR_BITS-1:cbfb_pkg::LANE_W];
		assign lane_data[l] = 8'(write_data >> {step, 3'b000});
		assign lane_en[l]   = (we_size == cbfb_pkg::SZ_BYTE) ? (step == '0) :
			(we_size == cbfb_pkg::SZ_HALF) ? !step[1] : 1'b1;
	end

	assign ob_lo = address[16:1];
	assign ob_hi = ob_lo + 16'd1;

	always_comb begin
		priority if (cbfb_pkg::action_t'(action) == cbfb_pkg::ACT_LOAD) begin
			op = cbfb_pkg::OP_ROM_LOAD;
		end else if (cbfb_pkg::action_t'(action) == cbfb_pkg::ACT_NOP) begin
			op = cbfb_pkg::OP_NONE;
		end else if (region >= cbfb_pkg::REGION_ROM_LO && region <= cbfb_pkg::REGION_ROM_HI)
		begin
			if (cbfb_pkg::action_t'(action) != cbfb_pkg::ACT_READ) begin
				op = cbfb_pkg::OP_NONE;
			end else if (rom_in_range) begin
				op = cbfb_pkg::OP_ROM_READ;
			end else if (size == cbfb_pkg::SZ_BYTE) begin
				op = cbfb_pkg::OP_UNMAPPED;
			end else begin
				op = cbfb_pkg::OP_OPEN_BUS;
			end
		end else if (region == cbfb_pkg::REGION_BACKUP && bk_present) begin
			if (cbfb_pkg::action_t'(action) == cbfb_pkg::ACT_READ) begin
				op = cbfb_pkg::OP_BK_READ;
			end else if (backup_kind == cbfb_pkg::BK_FLASH128) begin
				op = cbfb_pkg::OP_FL_WRITE;
			end else begin
				op = cbfb_pkg::OP_BK_WRITE;
			end
		end else begin
			op = cbfb_pkg::OP_UNMAPPED;
		end
	end

	always_comb begin
		cmd             = '0;
		cmd.op          = op;
		cmd.size        = size;
		cmd.lo2         = address[cbfb_pkg::LANE_W-1:0];
		cmd.rom_row     = rom_row;
		cmd.bk_row      = bk_row;
		cmd.lane_we     = lane_en;
		cmd.lane_data   = lane_data;
		cmd.const_data  = (size == cbfb_pkg::SZ_HALF) ? {16'b0, ob_lo} : {ob_hi, ob_lo};
		cmd.id_hit      = is_flash &&
			((bk_ofs == cbfb_pkg::ID_MAKER_OFS) || (bk_ofs == cbfb_pkg::ID_DEV_OFS));
		cmd.id_code     = (bk_ofs == cbfb_pkg::ID_DEV_OFS) ?
			((backup_kind == cbfb_pkg::BK_FLASH64) ? cbfb_pkg::ID_DEV64 : cbfb_pkg::ID_DEV128) :
			cbfb_pkg::ID_MAKER;
		cmd.fl.at_cmd1  = bk_ofs == cbfb_pkg::FL_CMD1_ADDR;
		cmd.fl.at_cmd2  = bk_ofs == cbfb_pkg::FL_CMD2_ADDR;
		cmd.fl.key1     = data_m == cbfb_pkg::FL_KEY1;
		cmd.fl.key2     = data_m == cbfb_pkg::FL_KEY2;
		cmd.fl.id_enter = data_m == cbfb_pkg::FL_ID_ENTER;
		cmd.fl.id_exit  = data_m == cbfb_pkg::FL_ID_EXIT;
	end

endmodule

@@ rtl/core/cbfb_queue.sv @@
// two-entry command queue between front decode and back end
// depends on cbfb_pkg
module cbfb_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  cbfb_pkg::cmd_t        cmd_in,
	input  logic                  pop,
	output cbfb_pkg::cmd_t        head,
	output cbfb_pkg::q_status_t   q_st
);

	cbfb_pkg::cmd_t                 mem_q [cbfb_pkg::Q_DEPTH];
	logic [cbfb_pkg::Q_PTR_W-1:0]   wr_ptr_q;
	logic [cbfb_pkg::Q_PTR_W-1:0]   rd_ptr_q;
	logic [cbfb_pkg::Q_CNT_W-1:0]   count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + cbfb_pkg::Q_CNT_W'(push) - cbfb_pkg::Q_CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	assign head           = mem_q[rd_ptr_q];
	assign q_st.not_empty = count_q != '0;
	assign q_st.full      = count_q == cbfb_pkg::Q_CNT_W'(cbfb_pkg::Q_DEPTH);

endmodule

@@ rtl/core/cbfb_back.sv @@
// back end: rom and backup banks, flash command tracking, result register
// depends on cbfb_pkg
module cbfb_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cbfb_pkg::q_status_t     q_st,
	input  cbfb_pkg::cmd_t          head,
	input  logic                    out_ready,
	output cbfb_pkg::back_status_t  bk_st,
	output logic                    out_valid,
	output logic [31:0]             out_data,
	output logic                    out_unm
);

	cbfb_pkg::back_state_t              state_q;
	cbfb_pkg::fl_phase_t                phase_q;
	cbfb_pkg::fl_phase_t                phase_d;
	logic                               chip_id_q;
	logic                               chip_id_d;
	logic [cbfb_pkg::BK_ROW_W-1:0]      clr_row_q;
	cbfb_pkg::cmd_t                     cmd_s1;
	logic                               out_valid_q;
	logic [31:0]                        out_data_q;
	logic                               out_unm_q;
	logic                               pop;
	logic                               clearing;
	logic                               fl_hit;
	logic [cbfb_pkg::LANES-1:0]         rom_we;
	logic [cbfb_pkg::LANES-1:0]         bk_we;
	logic [cbfb_pkg::LANES-1:0][7:0]    rom_lanes;
	logic [cbfb_pkg::LANES-1:0][7:0]    bk_lanes;
	logic [31:0]                        rd;
	logic                               unm;

	assign clearing = state_q == cbfb_pkg::ST_CLEAR;
	assign pop      = (state_q == cbfb_pkg::ST_IDLE) && q_st.not_empty &&
		(!out_valid_q || out_ready);

	// flash command sequence
	always_comb begin
		fl_hit    = 1'b0;
		phase_d   = phase_q;
		chip_id_d = chip_id_q;
		if (pop && head.op == cbfb_pkg::OP_FL_WRITE) begin
			priority if (phase_q == cbfb_pkg::PH_IDLE && head.fl.at_cmd1 && head.fl.key1) begin
				phase_d = cbfb_pkg::PH_KEY1;
				fl_hit  = 1'b1;
			end else if (phase_q == cbfb_pkg::PH_KEY1 && head.fl.at_cmd2 && head.fl.key2) begin
				phase_d = cbfb_pkg::PH_KEY2;
				fl_hit  = 1'b1;
			end else if (phase_q == cbfb_pkg::PH_KEY2 && head.fl.at_cmd1) begin
				phase_d = cbfb_pkg::PH_IDLE;
				fl_hit  = 1'b1;
				if (head.fl.id_enter) begin
					chip_id_d = 1'b1;
				end else if (head.fl.id_exit) begin
					chip_id_d = 1'b0;
				end
			end else begin
				phase_d = cbfb_pkg::PH_IDLE;
			end
		end
	end

	assign rom_we = (pop && head.op == cbfb_pkg::OP_ROM_LOAD) ? head.lane_we : '0;
	assign bk_we  = (pop && (head.op == cbfb_pkg::OP_BK_WRITE ||
		(head.op == cbfb_pkg::OP_FL_WRITE && !fl_hit))) ? head.lane_we : '0;

	for (genvar l = 0; l < cbfb_pkg::LANES; l++) begin : g_bank
		logic [7:0]                    rom_mem [cbfb_pkg::ROM_ROWS];
		logic [7:0]                    bk_mem [cbfb_pkg::BK_ROWS];
		logic [7:0]                    rom_rd_s1;
		logic [7:0]                    bk_rd_s1;
		logic [cbfb_pkg::BK_ROW_W-1:0] bk_addr;
		logic [7:0]                    bk_wdata;
		logic                          bk_wen;

		assign bk_addr  = clearing ? clr_row_q : head.bk_row[l];
		assign bk_wdata = clearing ? 8'hFF : head.lane_data[l];
		assign bk_wen   = clearing || bk_we[l];

		always_ff @(posedge clk) begin
			if (rom_we[l]) begin
				rom_mem[head.rom_row[l]] <= head.lane_data[l];
			end
			if (pop) begin
				rom_rd_s1 <= rom_mem[head.rom_row[l]];
			end
		end

		always_ff @(posedge clk) begin
			if (bk_wen) begin
				bk_mem[bk_addr] <= bk_wdata;
			end
			if (pop) begin
				bk_rd_s1 <= bk_mem[bk_addr];
			end
		end

		assign rom_lanes[l] = rom_rd_s1;
		assign bk_lanes[l]  = bk_rd_s1;
	end

	always_comb begin
		rd  = '0;
		unm = 1'b0;
		unique case (cmd_s1.op)
			cbfb_pkg::OP_ROM_READ: begin
				rd = cbfb_pkg::gather_bytes(rom_lanes, cmd_s1.lo2, cmd_s1.size);
			end
			cbfb_pkg::OP_BK_READ: begin
				rd = (cmd_s1.id_hit && chip_id_q) ? {24'b0, cmd_s1.id_code} :
					cbfb_pkg::gather_bytes(bk_lanes, cmd_s1.lo2, cmd_s1.size);
			end
			cbfb_pkg::OP_OPEN_BUS: begin
				rd = cmd_s1.const_data;
			end
			cbfb_pkg::OP_UNMAPPED: begin
				unm = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cbfb_pkg::ST_CLEAR;
			clr_row_q   <= '0;
			phase_q     <= cbfb_pkg::PH_IDLE;
			chip_id_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			chip_id_q <= chip_id_d;
			unique case (state_q)
				cbfb_pkg::ST_CLEAR: begin
					clr_row_q <= clr_row_q + 1'b1;
					if (clr_row_q == '1) begin
						state_q <= cbfb_pkg::ST_IDLE;
					end
				end
				cbfb_pkg::ST_IDLE: begin
					if (pop) begin
						state_q <= cbfb_pkg::ST_ACCESS;
					end
				end
				cbfb_pkg::ST_ACCESS: begin
					state_q <= cbfb_pkg::ST_IDLE;
				end
				default: begin
					state_q <= cbfb_pkg::ST_IDLE;
				end
			endcase
			if (state_q == cbfb_pkg::ST_ACCESS) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_s1 <= head;
		end
		if (state_q == cbfb_pkg::ST_ACCESS) begin
			out_data_q <= rd;
			out_unm_q  <= unm;
		end
	end

	assign bk_st.clearing = clearing;
	assign bk_st.pop      = pop;
	assign out_valid      = out_valid_q;
	assign out_data       = out_data_q;
	assign out_unm        = out_unm_q;

endmodule

@@ rtl/core/cartridge_bus_with_flash_backup.sv @@
// flow: the back end issues one queued access to the byte-lane banks and then forms
//   its result into the output register; it issues the next access only after that,
//   and only while the output register is empty or being taken by m_axis_tready
// reset: config registers go to 0, flash command state and chip-ID mode clear,
//   then a pass over all 32768 rows fills the backup banks with 0xFF; s_axis_tready stays low
//   during that pass while config writes are still taken
module cartridge_bus_with_flash_backup (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [0:0]                   cfg_index,
	input  logic [cbfb_pkg::CFG_W-1:0]   cfg_data,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [71:0]                  s_axis_tdata,  // address, access_width, write_data
	input  logic [1:0]                   s_axis_tuser,  // action
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [31:0]                  m_axis_tdata,  // read_data
	output logic [0:0]                   m_axis_tuser   // unmapped
);

	`include "cartridge_bus_with_flash_backup_defines.svh"

	logic [cbfb_pkg::KIND_W-1:0]  backup_kind_q;
	logic [cbfb_pkg::CFG_W-1:0]   rom_bytes_q;
	cbfb_pkg::cmd_t               cmd;
	cbfb_pkg::cmd_t               head;
	cbfb_pkg::q_status_t          q_st;
	cbfb_pkg::back_status_t       bk_st;
	logic                         push;
	logic                         out_unm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			backup_kind_q <= '0;
			rom_bytes_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cbfb_pkg::CFG_BACKUP_KIND: backup_kind_q <= cfg_data[cbfb_pkg::KIND_W-1:0];
				cbfb_pkg::CFG_ROM_BYTES:   rom_bytes_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign s_axis_tready = !q_st.full && !bk_st.clearing;
	assign push          = s_axis_tvalid && s_axis_tready;

	cbfb_front u_front (
		.action       (s_axis_tuser),
		.address      (s_axis_tdata[31:0]),
		.access_width (s_axis_tdata[33:32]),
		.write_data   (s_axis_tdata[65:34]),
		.backup_kind  (backup_kind_q),
		.rom_bytes    (rom_bytes_q),
		.cmd          (cmd)
	);

	cbfb_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.cmd_in (cmd),
		.pop    (bk_st.pop),
		.head   (head),
		.q_st   (q_st)
	);

	cbfb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_st      (q_st),
		.head      (head),
		.out_ready (m_axis_tready),
		.bk_st     (bk_st),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata),
		.out_unm   (out_unm)
	);

	assign m_axis_tuser = out_unm;

	`CBFB_ASSERT_IMP(a_no_transfer_in_clear, s_axis_tvalid && s_axis_tready, !bk_st.clearing)
	`CBFB_ASSERT_IMP(a_full_blocks_input, q_st.full, !s_axis_tready)
	`CBFB_ASSERT_NXT(a_issue_frees_output, bk_st.pop, !m_axis_tvalid)
	`CBFB_ASSERT_IMP(a_unmapped_reads_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0)

endmodule
